// ===== rtl/pbi_pkg.sv =====
// ----------------------------------------------------------------------------
// pbi_pkg
// Shared types and constants of the profile blink indicator.
// ----------------------------------------------------------------------------
package pbi_pkg;

    localparam int unsigned TimeWidth  = 16;
    localparam int unsigned FlashWidth = 8;
    localparam int unsigned IndexWidth = 8;
    localparam int unsigned BlinkWidth = IndexWidth + 1;
    localparam int unsigned CfgAddrWidth = 3;
    localparam int unsigned CfgDataWidth = TimeWidth;

    // Configuration register indexes
    typedef enum logic [CfgAddrWidth-1:0] {
        REG_BLINK_ON_TIME     = 3'd0,
        REG_BLINK_OFF_TIME    = 3'd1,
        REG_END_PAUSE_TIME    = 3'd2,
        REG_CLEAR_ON_TIME     = 3'd3,
        REG_CLEAR_OFF_TIME    = 3'd4,
        REG_FLASH_TOTAL       = 3'd5,
        REG_START_DELAY       = 3'd6,
        REG_PINS_ACTIVE_LOW   = 3'd7
    } pbi_reg_t;

    // Reset values
    localparam logic [TimeWidth-1:0]  RstBlinkOnTime    = 16'd200;
    localparam logic [TimeWidth-1:0]  RstBlinkOffTime   = 16'd200;
    localparam logic [TimeWidth-1:0]  RstEndPauseTime   = 16'd800;
    localparam logic [TimeWidth-1:0]  RstClearOnTime    = 16'd80;
    localparam logic [TimeWidth-1:0]  RstClearOffTime   = 16'd80;
    localparam logic [FlashWidth-1:0] RstFlashTotal     = 8'd5;
    localparam logic [TimeWidth-1:0]  RstStartDelay     = 16'd50;
    localparam logic                  RstPinsActiveLow  = 1'b1;
    localparam logic [IndexWidth-1:0] RstPrevIndex      = 8'hFF;

    // Item kinds
    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_EVENT = 1'b1;

    typedef struct packed {
        logic [TimeWidth-1:0]  blink_on_time;
        logic [TimeWidth-1:0]  blink_off_time;
        logic [TimeWidth-1:0]  end_pause_time;
        logic [TimeWidth-1:0]  clear_on_time;
        logic [TimeWidth-1:0]  clear_off_time;
        logic [FlashWidth-1:0] flash_total;
        logic [TimeWidth-1:0]  start_delay;
        logic                  pins_active_low;
    } pbi_cfg_t;

    typedef struct packed {
        logic                  func;
        logic [IndexWidth-1:0] prof_num;
        logic                  link_connected;
    } pbi_in_t;

    typedef struct packed {
        logic count_led_pin;
        logic link_led_pin;
        logic pattern_busy;
    } pbi_out_t;

endpackage

// ===== rtl/pbi_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pbi_cfg_regs
// Configuration register file; takes one write transaction per cycle.
// ----------------------------------------------------------------------------
module pbi_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [pbi_pkg::CfgAddrWidth-1:0]  wr_addr,
    input  logic [pbi_pkg::CfgDataWidth-1:0]  wr_data,
    output pbi_pkg::pbi_cfg_t                 cfg
);
    import pbi_pkg::*;

    pbi_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.blink_on_time     <= RstBlinkOnTime;
            cfg_reg.blink_off_time    <= RstBlinkOffTime;
            cfg_reg.end_pause_time    <= RstEndPauseTime;
            cfg_reg.clear_on_time     <= RstClearOnTime;
            cfg_reg.clear_off_time    <= RstClearOffTime;
            cfg_reg.flash_total       <= RstFlashTotal;
            cfg_reg.start_delay       <= RstStartDelay;
            cfg_reg.pins_active_low   <= RstPinsActiveLow;
        end else if (wr_en) begin
            unique case (pbi_reg_t'(wr_addr))
                REG_BLINK_ON_TIME:     cfg_reg.blink_on_time  <= wr_data;
                REG_BLINK_OFF_TIME:    cfg_reg.blink_off_time <= wr_data;
                REG_END_PAUSE_TIME:    cfg_reg.end_pause_time <= wr_data;
                REG_CLEAR_ON_TIME:     cfg_reg.clear_on_time  <= wr_data;
                REG_CLEAR_OFF_TIME:    cfg_reg.clear_off_time <= wr_data;
                REG_FLASH_TOTAL:       cfg_reg.flash_total    <= wr_data[FlashWidth-1:0];
                REG_START_DELAY:       cfg_reg.start_delay    <= wr_data;
                REG_PINS_ACTIVE_LOW:   cfg_reg.pins_active_low <= wr_data[0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/pbi_core.sv =====
// ----------------------------------------------------------------------------
// pbi_core
// Blink pattern state and its combinational update per transaction.
// ----------------------------------------------------------------------------
module pbi_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step_en,
    input  pbi_pkg::pbi_in_t   item,
    input  pbi_pkg::pbi_cfg_t  cfg,
    output pbi_pkg::pbi_out_t  result
);
    import pbi_pkg::*;

    logic [TimeWidth-1:0]  delay_left_reg,    delay_left_next;
    logic                  step_armed_reg,    step_armed_next;
    logic [BlinkWidth-1:0] blinks_wanted_reg, blinks_wanted_next;
    logic [BlinkWidth-1:0] blinks_done_reg,   blinks_done_next;
    logic                  lit_phase_reg,     lit_phase_next;
    logic                  link_up_reg,       link_up_next;
    logic                  clear_pattern_reg, clear_pattern_next;
    logic [IndexWidth-1:0] prev_index_reg,    prev_index_next;
    logic                  prev_conn_reg,     prev_conn_next;
    logic                  count_lit_reg,     count_lit_next;
    logic                  link_lit_reg,      link_lit_next;

    logic [TimeWidth-1:0]  on_t, off_t;
    logic [BlinkWidth-1:0] done_inc;
    logic                  is_clear;

    always_comb begin
        delay_left_next    = delay_left_reg;
        step_armed_next    = step_armed_reg;
        blinks_wanted_next = blinks_wanted_reg;
        blinks_done_next   = blinks_done_reg;
        lit_phase_next     = lit_phase_reg;
        link_up_next       = link_up_reg;
        clear_pattern_next = clear_pattern_reg;
        prev_index_next    = prev_index_reg;
        prev_conn_next     = prev_conn_reg;
        count_lit_next     = count_lit_reg;
        link_lit_next      = link_lit_reg;

        on_t     = clear_pattern_reg ? cfg.clear_on_time  : cfg.blink_on_time;
        off_t    = clear_pattern_reg ? cfg.clear_off_time : cfg.blink_off_time;
        done_inc = blinks_done_reg + BlinkWidth'(1);
        is_clear = (item.prof_num == prev_index_reg) && prev_conn_reg
                   && !item.link_connected;

        if (item.func == FUNC_TICK) begin
            if (step_armed_reg) begin
                if (delay_left_reg[TimeWidth-1:1] == '0) begin
                    // fire the scheduled step
                    delay_left_next = '0;
                    step_armed_next = 1'b0;
                    if (blinks_done_reg >= blinks_wanted_reg) begin
                        count_lit_next     = 1'b0;
                        link_lit_next      = link_up_reg;
                        clear_pattern_next = 1'b0;
                    end else if (lit_phase_reg) begin
                        count_lit_next = 1'b0;
                        if (clear_pattern_reg) begin
                            link_lit_next = 1'b0;
                        end
                        lit_phase_next   = 1'b0;
                        blinks_done_next = done_inc;
                        delay_left_next  = (done_inc >= blinks_wanted_reg) ?
                                           cfg.end_pause_time : off_t;
                        step_armed_next  = 1'b1;
                    end else begin
                        count_lit_next = 1'b1;
                        if (clear_pattern_reg) begin
                            link_lit_next = 1'b1;
                        end
                        lit_phase_next  = 1'b1;
                        delay_left_next = on_t;
                        step_armed_next = 1'b1;
                    end
                end else begin
                    delay_left_next = delay_left_reg - TimeWidth'(1);
                end
            end
        end else begin
            if (is_clear) begin
                clear_pattern_next = 1'b1;
                link_up_next       = 1'b0;
                blinks_wanted_next = BlinkWidth'(cfg.flash_total);
            end else begin
                link_up_next       = item.link_connected;
                clear_pattern_next = 1'b0;
                link_lit_next      = item.link_connected;
                blinks_wanted_next = BlinkWidth'(item.prof_num) + BlinkWidth'(1);
            end
            blinks_done_next = '0;
            lit_phase_next   = 1'b0;
            delay_left_next  = cfg.start_delay;
            step_armed_next  = 1'b1;
            prev_index_next  = item.prof_num;
            prev_conn_next   = item.link_connected;
        end

        result.count_led_pin = count_lit_next ^ cfg.pins_active_low;
        result.link_led_pin  = link_lit_next ^ cfg.pins_active_low;
        result.pattern_busy  = step_armed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_left_reg    <= '0;
            step_armed_reg    <= 1'b0;
            blinks_wanted_reg <= '0;
            blinks_done_reg   <= '0;
            lit_phase_reg     <= 1'b0;
            link_up_reg       <= 1'b0;
            clear_pattern_reg <= 1'b0;
            prev_index_reg    <= RstPrevIndex;
            prev_conn_reg     <= 1'b0;
            count_lit_reg     <= 1'b0;
            link_lit_reg      <= 1'b0;
        end else if (step_en) begin
            delay_left_reg    <= delay_left_next;
            step_armed_reg    <= step_armed_next;
            blinks_wanted_reg <= blinks_wanted_next;
            blinks_done_reg   <= blinks_done_next;
            lit_phase_reg     <= lit_phase_next;
            link_up_reg       <= link_up_next;
            clear_pattern_reg <= clear_pattern_next;
            prev_index_reg    <= prev_index_next;
            prev_conn_reg     <= prev_conn_next;
            count_lit_reg     <= count_lit_next;
            link_lit_reg      <= link_lit_next;
        end
    end

endmodule

// ===== rtl/profile_blink_indicator.sv =====
// ----------------------------------------------------------------------------
// profile_blink_indicator
// Count LED / link LED pattern generator driven by ticks and profile events.
// ----------------------------------------------------------------------------
// Every input transaction (a millisecond tick or a profile-change event)
// yields exactly one result transaction carrying both LED pin levels and a
// busy flag, in order. The block sustains one transaction per cycle while
// the downstream side keeps m_ready high; a transaction passes through the
// input register, the pattern update and the result register. While the
// result register waits on the downstream side, the input register takes
// one more transaction and then holds s_ready low until the result drains.
// Configuration writes are accepted every cycle and should be issued only
// while no transaction is in flight.
// ----------------------------------------------------------------------------
module profile_blink_indicator (
    input  logic                              aclk,
    input  logic                              aresetn,

    // item input
    input  logic                              s_valid,
    output logic                              s_ready,
    input  pbi_pkg::pbi_in_t                  s_data,

    // result output
    output logic                              m_valid,
    input  logic                              m_ready,
    output pbi_pkg::pbi_out_t                 m_data,

    // configuration write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pbi_pkg::CfgAddrWidth-1:0]  cfg_addr,
    input  logic [pbi_pkg::CfgDataWidth-1:0]  cfg_wdata
);
    import pbi_pkg::*;

    pbi_cfg_t  cfg;
    pbi_in_t   in_data_reg;
    logic      in_valid_reg;
    pbi_out_t  out_data_reg;
    logic      out_valid_reg;
    pbi_out_t  core_result;
    logic      out_free;
    logic      advance;

    // Result register is free when empty or being drained this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // Move the held transaction through the pattern update into the result.
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign cfg_ready = 1'b1;

    pbi_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (cfg_valid),
        .wr_addr (cfg_addr),
        .wr_data (cfg_wdata),
        .cfg     (cfg)
    );

    pbi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .item    (in_data_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Input register: capture a new transaction whenever it drains or is empty.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // Result register: hold until the downstream side takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
